/* rtl/kufef_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the kruskal union-find edge filter
package kufef_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VERTEX_W     = $clog2(MAX_VERTICES);
    localparam int INDEX_W      = VERTEX_W + 1;
    localparam int CFG_W        = 11;
    localparam int RANK_W       = 4;
    localparam int COUNT_W      = 10;
    localparam int WEIGHT_W     = 16;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [RANK_W-1:0]   t_rank;
    typedef logic [COUNT_W-1:0]  t_count;

    localparam t_rank  RANK_MAX   = {RANK_W{1'b1}};
    localparam t_rank  RANK_INC   = t_rank'(1);
    localparam t_count COUNT_MAX  = {COUNT_W{1'b1}};
    localparam t_count COUNT_INC  = t_count'(1);
    localparam t_index INDEX_INC  = t_index'(1);
    localparam t_index INDEX_FULL = t_index'(MAX_VERTICES);

    // action codes
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    // requests from the sequencer to the parent and rank stores
    typedef struct packed {
        logic    p_we;
        t_vertex p_waddr;
        t_vertex p_wdata;
        t_vertex p_raddr;
        logic    r_we;
        t_vertex r_waddr;
        t_rank   r_wdata;
        t_vertex r_raddr;
    } t_store_req;

    // registered read data back from the stores
    typedef struct packed {
        t_vertex p_rdata;
        t_rank   r_rdata;
    } t_store_rsp;

endpackage

/* rtl/kufef_store.sv */
`timescale 1ns / 1ps
// parent and rank memories, one write and one registered read each
module kufef_store (
    input  logic                  i_clk,
    input  kufef_pkg::t_store_req i_req,
    output kufef_pkg::t_store_rsp o_rsp
);

    kufef_pkg::t_vertex r_parent_mem [kufef_pkg::MAX_VERTICES];
    kufef_pkg::t_rank   r_rank_mem   [kufef_pkg::MAX_VERTICES];
    kufef_pkg::t_vertex r_p_rdata;
    kufef_pkg::t_rank   r_r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.p_we) begin
            r_parent_mem[i_req.p_waddr] <= i_req.p_wdata;
        end
        r_p_rdata <= r_parent_mem[i_req.p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.r_we) begin
            r_rank_mem[i_req.r_waddr] <= i_req.r_wdata;
        end
        r_r_rdata <= r_rank_mem[i_req.r_raddr];
    end

    assign o_rsp.p_rdata = r_p_rdata;
    assign o_rsp.r_rdata = r_r_rdata;

endmodule

/* rtl/kufef_seq.sv */
`timescale 1ns / 1ps
// sequencer: clear sweep, root walks with path compression, union by rank
module kufef_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_action,
    input  kufef_pkg::t_vertex      i_vertex_a,
    input  kufef_pkg::t_vertex      i_vertex_b,
    input  logic [kufef_pkg::WEIGHT_W-1:0] i_weight,
    input  kufef_pkg::t_index       i_active,
    input  kufef_pkg::t_store_rsp   i_rsp,
    output kufef_pkg::t_store_req   o_req,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic                    o_accepted,
    output logic                    o_bad_vertex,
    output kufef_pkg::t_count       o_tree_edge_count,
    output logic                    o_all_unit_weight
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_FIND_A,
        ST_CMP_A,
        ST_FIND_B,
        ST_CMP_B,
        ST_RANK,
        ST_JOIN
    } t_state;

    t_state             r_state, n_state;
    kufef_pkg::t_vertex r_cur, n_cur;
    kufef_pkg::t_vertex r_va, n_va;
    kufef_pkg::t_vertex r_vb, n_vb;
    kufef_pkg::t_vertex r_ra, n_ra;
    kufef_pkg::t_vertex r_rb, n_rb;
    kufef_pkg::t_rank   r_rka, n_rka;
    logic               r_heavy, n_heavy;
    kufef_pkg::t_index  r_idx, n_idx;
    kufef_pkg::t_index  r_limit, n_limit;
    kufef_pkg::t_count  r_count, n_count;
    logic               r_unit, n_unit;
    logic               r_valid, n_valid;
    logic               r_acc, n_acc;
    logic               r_bad, n_bad;

    kufef_pkg::t_vertex w_pd;
    kufef_pkg::t_rank   w_rkb;
    logic               w_accept;
    logic               w_bad_in;

    assign w_pd     = i_rsp.p_rdata;
    assign w_rkb    = i_rsp.r_rdata;
    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_bad_in = ({1'b0, i_vertex_a} >= i_active) || ({1'b0, i_vertex_b} >= i_active);

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_va    = r_va;
        n_vb    = r_vb;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_rka   = r_rka;
        n_heavy = r_heavy;
        n_idx   = r_idx;
        n_limit = r_limit;
        n_count = r_count;
        n_unit  = r_unit;
        n_valid = 1'b0;
        n_acc   = r_acc;
        n_bad   = r_bad;
        o_req   = '0;
        o_req.p_raddr = r_cur;
        o_req.r_raddr = r_ra;

        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                if (r_idx == r_limit) begin
                    n_state = ST_IDLE;
                    if (r_state == ST_CLEAR) begin
                        n_count = '0;
                        n_unit  = 1'b1;
                        n_acc   = 1'b0;
                        n_bad   = 1'b0;
                        n_valid = 1'b1;
                    end
                end else begin
                    // singleton set of rank zero
                    o_req.p_we    = 1'b1;
                    o_req.p_waddr = r_idx[kufef_pkg::VERTEX_W-1:0];
                    o_req.p_wdata = r_idx[kufef_pkg::VERTEX_W-1:0];
                    o_req.r_we    = 1'b1;
                    o_req.r_waddr = r_idx[kufef_pkg::VERTEX_W-1:0];
                    o_req.r_wdata = '0;
                    n_idx         = r_idx + kufef_pkg::INDEX_INC;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == kufef_pkg::ACT_CLEAR) begin
                        n_idx   = '0;
                        n_limit = i_active;
                        n_state = ST_CLEAR;
                    end else if (w_bad_in) begin
                        n_acc   = 1'b0;
                        n_bad   = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        n_va          = i_vertex_a;
                        n_vb          = i_vertex_b;
                        n_cur         = i_vertex_a;
                        n_heavy       = (i_weight > kufef_pkg::WEIGHT_W'(1));
                        o_req.p_raddr = i_vertex_a;
                        n_state       = ST_FIND_A;
                    end
                end
            end
            ST_FIND_A, ST_FIND_B: begin
                if (w_pd == r_cur) begin
                    // root found, restart from the endpoint to compress
                    if (r_state == ST_FIND_A) begin
                        n_ra    = r_cur;
                        n_cur   = r_va;
                        n_state = ST_CMP_A;
                    end else begin
                        n_rb    = r_cur;
                        n_cur   = r_vb;
                        n_state = ST_CMP_B;
                    end
                    o_req.p_raddr = n_cur;
                end else begin
                    n_cur         = w_pd;
                    o_req.p_raddr = w_pd;
                end
            end
            ST_CMP_A: begin
                if (w_pd == r_cur) begin
                    n_cur         = r_vb;
                    o_req.p_raddr = r_vb;
                    n_state       = ST_FIND_B;
                end else begin
                    o_req.p_we    = 1'b1;
                    o_req.p_waddr = r_cur;
                    o_req.p_wdata = r_ra;
                    n_cur         = w_pd;
                    o_req.p_raddr = w_pd;
                end
            end
            ST_CMP_B: begin
                if (w_pd == r_cur) begin
                    if (r_ra == r_rb) begin
                        n_acc   = 1'b0;
                        n_bad   = 1'b0;
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_req.r_raddr = r_ra;
                        n_state       = ST_RANK;
                    end
                end else begin
                    o_req.p_we    = 1'b1;
                    o_req.p_waddr = r_cur;
                    o_req.p_wdata = r_rb;
                    n_cur         = w_pd;
                    o_req.p_raddr = w_pd;
                end
            end
            ST_RANK: begin
                n_rka         = w_rkb;
                o_req.r_raddr = r_rb;
                n_state       = ST_JOIN;
            end
            ST_JOIN: begin
                o_req.p_we = 1'b1;
                if (r_rka > w_rkb) begin
                    o_req.p_waddr = r_rb;
                    o_req.p_wdata = r_ra;
                end else begin
                    o_req.p_waddr = r_ra;
                    o_req.p_wdata = r_rb;
                    if ((r_rka == w_rkb) && (w_rkb != kufef_pkg::RANK_MAX)) begin
                        o_req.r_we    = 1'b1;
                        o_req.r_waddr = r_rb;
                        o_req.r_wdata = w_rkb + kufef_pkg::RANK_INC;
                    end
                end
                if (r_count != kufef_pkg::COUNT_MAX) begin
                    n_count = r_count + kufef_pkg::COUNT_INC;
                end
                if (r_heavy) begin
                    n_unit = 1'b0;
                end
                n_acc   = 1'b1;
                n_bad   = 1'b0;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_idx   <= '0;
            r_limit <= kufef_pkg::INDEX_FULL;
            r_count <= '0;
            r_unit  <= 1'b1;
            r_valid <= 1'b0;
            r_acc   <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_limit <= n_limit;
            r_count <= n_count;
            r_unit  <= n_unit;
            r_valid <= n_valid;
            r_acc   <= n_acc;
            r_bad   <= n_bad;
        end
        r_cur   <= n_cur;
        r_va    <= n_va;
        r_vb    <= n_vb;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_rka   <= n_rka;
        r_heavy <= n_heavy;
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_valid           = r_valid;
    assign o_accepted        = r_acc;
    assign o_bad_vertex      = r_bad;
    assign o_tree_edge_count = r_count;
    assign o_all_unit_weight = r_unit;

endmodule

/* rtl/kruskal_union_find_edge_filter_top.sv */
`timescale 1ns / 1ps
// top level of the kruskal union-find edge filter
// an edge finds and compresses a's root path, then b's, then reads both ranks and joins;
//   a same-set edge stops after b's path; a bad endpoint is answered in the next cycle
// throughput: one item at a time, one parent link per cycle; a new start is taken in the
//   cycle the result beat shows; results are one-cycle beats, the receiver cannot stall
// reset: synchronous active low, busy high for the store init, vertex_count 1024
module kruskal_union_find_edge_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_action,
    input  logic [kufef_pkg::VERTEX_W-1:0]    i_vertex_a,
    input  logic [kufef_pkg::VERTEX_W-1:0]    i_vertex_b,
    input  logic [kufef_pkg::WEIGHT_W-1:0]    i_weight,
    // vertex_count register
    input  logic                              i_cfg_we,
    input  logic [kufef_pkg::CFG_W-1:0]       i_cfg_wdata,
    // result beat
    output logic                              o_valid,
    output logic                              o_accepted,
    output logic                              o_bad_vertex,
    output logic [kufef_pkg::COUNT_W-1:0]     o_tree_edge_count,
    output logic                              o_all_unit_weight
);

    logic [kufef_pkg::CFG_W-1:0] r_vertex_count;
    kufef_pkg::t_index           w_active;
    kufef_pkg::t_store_req       w_req;
    kufef_pkg::t_store_rsp       w_rsp;

    // vertex_count register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= kufef_pkg::CFG_W'(kufef_pkg::MAX_VERTICES);
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // counts above the store depth act as the full depth
    assign w_active = (r_vertex_count > kufef_pkg::CFG_W'(kufef_pkg::MAX_VERTICES))
                    ? kufef_pkg::INDEX_FULL
                    : kufef_pkg::INDEX_W'(r_vertex_count);

    // sequencer owns the walk, compression and join
    kufef_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_action          (i_action),
        .i_vertex_a        (i_vertex_a),
        .i_vertex_b        (i_vertex_b),
        .i_weight          (i_weight),
        .i_active          (w_active),
        .i_rsp             (w_rsp),
        .o_req             (w_req),
        .o_busy            (busy),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_bad_vertex      (o_bad_vertex),
        .o_tree_edge_count (o_tree_edge_count),
        .o_all_unit_weight (o_all_unit_weight)
    );

    // parent and rank memories
    kufef_store u_store (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

endmodule
